// ===== hw/rtl/eih_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// eih_pkg: shared types and constants for the encoder index homing block
// Holds the phase encoding, the register map and the register reset values.
// ============================================================================
package eih_pkg;

   // Default sizes of the drive output and of the internal position words
   localparam int DRIVE_BITS_DEFAULT = 16;
   localparam int POS_BITS_DEFAULT   = 32;

   // Error terms are limited to +-2^TERM_SHIFT before the gains
   localparam int TERM_SHIFT = 52;
   // Signed width that holds +-2^TERM_SHIFT
   localparam int ERR_CAP    = TERM_SHIFT + 2;

   // Settle counter
   localparam int STILL_BITS = 17;
   localparam logic [STILL_BITS-1:0] STILL_MAX = '1;

   // Field widths fixed by the interface
   localparam int FIELD_BITS  = 32;
   localparam int PHASE_BITS  = 3;
   localparam int CSR_IDX_BITS = 3;
   localparam int STEP_BITS   = 12;
   localparam int LIMIT_BITS  = 16;
   localparam int GAIN_BITS   = 8;

   // Input item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Homing phases
   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE      = 3'd0,
      PH_WAITLOW   = 3'd1,
      PH_TRAVEL    = 3'd2,
      PH_WAITLATCH = 3'd3,
      PH_SETTLE    = 3'd4,
      PH_DONE      = 3'd5
   } phase_type;

   // Register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_STEP_PER_TICK  = 3'd0,
      CSR_ERROR_LIMIT    = 3'd1,
      CSR_GAIN_POSITION  = 3'd2,
      CSR_GAIN_VELOCITY  = 3'd3,
      CSR_TRAVEL_MINIMUM = 3'd4,
      CSR_STILL_NEEDED   = 3'd5,
      CSR_HOME_OFFSET    = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [STEP_BITS-1:0]         RST_STEP_PER_TICK  = 12'd12;
   localparam logic [LIMIT_BITS-1:0]        RST_ERROR_LIMIT    = 16'd3000;
   localparam logic [GAIN_BITS-1:0]         RST_GAIN_POSITION  = 8'd2;
   localparam logic [GAIN_BITS-1:0]         RST_GAIN_VELOCITY  = 8'd20;
   localparam logic [LIMIT_BITS-1:0]        RST_TRAVEL_MINIMUM = 16'd800;
   localparam logic [LIMIT_BITS-1:0]        RST_STILL_NEEDED   = 16'd1000;
   localparam logic signed [FIELD_BITS-1:0] RST_HOME_OFFSET    = 32'sd0;

endpackage

// ===== hw/rtl/encoder_index_homing.sv =====
`timescale 1ns / 1ps
// ============================================================================
// encoder_index_homing: index pulse homing sequencer for one steering axis
// Runs the PD homing drive, finds the index position and issues the encoder
// preset once the axis has settled.
// ============================================================================
// One result per input transaction, one transaction per clock sustained while
// the result side is ready. An item passes three registers (input, state
// update, drive output). The state update stage is the only place where the
// homing state is read and written, which lets the next item follow right
// behind. The PD products are formed in the last stage. The user must write
// the configuration registers through the csr_ port only while no
// transaction is in flight; the block itself does not enforce this.
module encoder_index_homing #(
   parameter int DRIVE_BITS = eih_pkg::DRIVE_BITS_DEFAULT,
   parameter int POS_BITS   = eih_pkg::POS_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration write port
   input  logic                                   csr_we,
   input  logic [eih_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [eih_pkg::FIELD_BITS-1:0]         csr_wdata,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic signed [eih_pkg::FIELD_BITS-1:0]  req_position,
   input  logic signed [eih_pkg::FIELD_BITS-1:0]  req_position_reread,
   input  logic                                   req_index_level,
   input  logic                                   req_index_latched,
   // results
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [DRIVE_BITS-1:0]           rsp_drive,
   output logic                                   rsp_clear_latch,
   output logic [eih_pkg::PHASE_BITS-1:0]         rsp_phase,
   output logic                                   rsp_preset_valid,
   output logic signed [eih_pkg::FIELD_BITS-1:0]  rsp_preset_value
);

   localparam int FB       = eih_pkg::FIELD_BITS;
   localparam int ERR_BITS = (POS_BITS > eih_pkg::ERR_CAP) ? eih_pkg::ERR_CAP : POS_BITS;
   localparam int PROD_BITS = ERR_BITS + eih_pkg::GAIN_BITS + 1;
   localparam int SUM_BITS = (PROD_BITS + 1 > DRIVE_BITS + 1) ? PROD_BITS + 1 : DRIVE_BITS + 1;
   localparam int CMP_BITS = ((POS_BITS > eih_pkg::LIMIT_BITS) ? POS_BITS
                                                                : eih_pkg::LIMIT_BITS) + 1;
   localparam int PRE_BITS = (POS_BITS > FB) ? POS_BITS : FB;
   localparam logic signed [POS_BITS-1:0] TERM_HI =
      POS_BITS'(64'sd1 <<< eih_pkg::TERM_SHIFT);
   localparam logic signed [SUM_BITS-1:0] DRV_HI =
      SUM_BITS'((64'sd1 <<< (DRIVE_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_BITS-1:0] DRV_LO = -DRV_HI - SUM_BITS'(1);

   // Limit an error term to +-2^TERM_SHIFT and narrow it
   function automatic logic signed [ERR_BITS-1:0] sat_term(
      input logic signed [POS_BITS-1:0] v);
      logic signed [POS_BITS-1:0] c;
      c = v;
      if (POS_BITS > eih_pkg::ERR_CAP - 1) begin
         if (v > TERM_HI) begin
            c = TERM_HI;
         end else if (v < -TERM_HI) begin
            c = -TERM_HI;
         end
      end
      return ERR_BITS'(c);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [eih_pkg::STEP_BITS-1:0]   cfg_step_ff;
   logic [eih_pkg::LIMIT_BITS-1:0]  cfg_limit_ff;
   logic [eih_pkg::GAIN_BITS-1:0]   cfg_kp_ff;
   logic [eih_pkg::GAIN_BITS-1:0]   cfg_kd_ff;
   logic [eih_pkg::LIMIT_BITS-1:0]  cfg_travel_ff;
   logic [eih_pkg::LIMIT_BITS-1:0]  cfg_still_ff;
   logic signed [FB-1:0]            cfg_home_ff;

   // Write the addressed register; drop writes beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_step_ff   <= eih_pkg::RST_STEP_PER_TICK;
         cfg_limit_ff  <= eih_pkg::RST_ERROR_LIMIT;
         cfg_kp_ff     <= eih_pkg::RST_GAIN_POSITION;
         cfg_kd_ff     <= eih_pkg::RST_GAIN_VELOCITY;
         cfg_travel_ff <= eih_pkg::RST_TRAVEL_MINIMUM;
         cfg_still_ff  <= eih_pkg::RST_STILL_NEEDED;
         cfg_home_ff   <= eih_pkg::RST_HOME_OFFSET;
      end else if (csr_we) begin
         case (eih_pkg::csr_index_type'(csr_index))
            eih_pkg::CSR_STEP_PER_TICK:  cfg_step_ff   <= csr_wdata[eih_pkg::STEP_BITS-1:0];
            eih_pkg::CSR_ERROR_LIMIT:    cfg_limit_ff  <= csr_wdata[eih_pkg::LIMIT_BITS-1:0];
            eih_pkg::CSR_GAIN_POSITION:  cfg_kp_ff     <= csr_wdata[eih_pkg::GAIN_BITS-1:0];
            eih_pkg::CSR_GAIN_VELOCITY:  cfg_kd_ff     <= csr_wdata[eih_pkg::GAIN_BITS-1:0];
            eih_pkg::CSR_TRAVEL_MINIMUM: cfg_travel_ff <= csr_wdata[eih_pkg::LIMIT_BITS-1:0];
            eih_pkg::CSR_STILL_NEEDED:   cfg_still_ff  <= csr_wdata[eih_pkg::LIMIT_BITS-1:0];
            eih_pkg::CSR_HOME_OFFSET:    cfg_home_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control: each stage takes a new transaction when it is
   // empty or when its content moves on in the same cycle
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;
   logic s1_load, s2_load, s3_load;

   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign s1_load   = req_valid && s1_ready;
   assign s2_load   = s1_valid_ff && s2_ready;
   assign s3_load   = s2_valid_ff && s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: input register
   // ------------------------------------------------------------------------
   logic                 s1_kind_ff;
   logic signed [FB-1:0] s1_pos_ff;
   logic signed [FB-1:0] s1_reread_ff;
   logic                 s1_level_ff;
   logic                 s1_latched_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_kind_ff    <= req_kind;
         s1_pos_ff     <= req_position;
         s1_reread_ff  <= req_position_reread;
         s1_level_ff   <= req_index_level;
         s1_latched_ff <= req_index_latched;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: homing state
   // ------------------------------------------------------------------------
   eih_pkg::phase_type phase_ff, phase_in;
   logic signed [POS_BITS-1:0]        desired_ff, desired_in;
   logic signed [POS_BITS-1:0]        previous_ff, previous_in;
   logic signed [POS_BITS-1:0]        edge_ff, edge_in;
   logic signed [POS_BITS-1:0]        found_ff, found_in;
   logic [eih_pkg::STILL_BITS-1:0]    still_ff, still_in;

   logic signed [POS_BITS-1:0] pos_w;
   logic signed [POS_BITS-1:0] desired_step;
   logic signed [POS_BITS-1:0] lead;
   logic signed [POS_BITS-1:0] travel;
   logic signed [POS_BITS-1:0] err_pos_w;
   logic signed [POS_BITS-1:0] err_vel_w;
   logic signed [CMP_BITS-1:0] lead_x, limit_x, travel_x, travel_min_x;
   logic signed [FB:0]         pair_sum, pair_rnd, pair_half;
   logic signed [FB-1:0]       pair_avg;
   logic signed [PRE_BITS-1:0] preset_w;
   logic [eih_pkg::STILL_BITS-1:0] still_step;
   logic is_tick, is_active, idx_low, lead_over, travel_done, still_done;

   assign pos_w   = POS_BITS'(s1_pos_ff);
   assign is_tick = (s1_kind_ff == eih_pkg::KIND_TICK);
   assign idx_low = !s1_level_ff;
   assign is_active = is_tick && (phase_ff == eih_pkg::PH_WAITLOW ||
                                  phase_ff == eih_pkg::PH_TRAVEL ||
                                  phase_ff == eih_pkg::PH_WAITLATCH);

   // Desired position advance and lead limit
   assign desired_step = desired_ff + POS_BITS'(cfg_step_ff);
   assign lead         = desired_step - pos_w;
   assign lead_x       = CMP_BITS'(lead);
   assign limit_x      = $signed(CMP_BITS'(cfg_limit_ff));
   assign lead_over    = (lead_x > limit_x);

   // Travel since the index went low
   assign travel       = pos_w - edge_ff;
   assign travel_x     = CMP_BITS'(travel);
   assign travel_min_x = $signed(CMP_BITS'(cfg_travel_ff));
   assign travel_done  = (travel_x > travel_min_x);

   // Settle counter, saturating
   always_comb begin
      if (pos_w != previous_ff) begin
         still_step = '0;
      end else if (still_ff != eih_pkg::STILL_MAX) begin
         still_step = still_ff + eih_pkg::STILL_BITS'(1);
      end else begin
         still_step = still_ff;
      end
   end
   assign still_done = (still_step > eih_pkg::STILL_BITS'(cfg_still_ff));

   // Average of the two reads, truncated toward zero
   assign pair_sum  = (FB + 1)'(s1_pos_ff) + (FB + 1)'(s1_reread_ff);
   assign pair_rnd  = pair_sum + $signed({{FB{1'b0}}, pair_sum[FB]});
   assign pair_half = pair_rnd >>> 1;
   assign pair_avg  = pair_half[FB-1:0];

   assign preset_w = PRE_BITS'(pos_w) - PRE_BITS'(found_ff);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (!is_tick) begin
         phase_in = eih_pkg::PH_WAITLOW;
      end else begin
         case (phase_ff)
            eih_pkg::PH_WAITLOW: begin
               if (idx_low) begin
                  phase_in = eih_pkg::PH_TRAVEL;
               end
            end
            eih_pkg::PH_TRAVEL: begin
               if (!idx_low) begin
                  phase_in = eih_pkg::PH_WAITLOW;
               end else if (travel_done) begin
                  phase_in = eih_pkg::PH_WAITLATCH;
               end
            end
            eih_pkg::PH_WAITLATCH: begin
               if (s1_latched_ff) begin
                  phase_in = eih_pkg::PH_SETTLE;
               end
            end
            eih_pkg::PH_SETTLE: begin
               if (still_done) begin
                  phase_in = eih_pkg::PH_DONE;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // State and result fields of the state stage
   logic                       s2_clear_in, s2_pvalid_in;
   logic signed [FB-1:0]       s2_preset_in;
   logic signed [ERR_BITS-1:0] s2_err_pos_in, s2_err_vel_in;

   always_comb begin
      desired_in    = desired_ff;
      previous_in   = previous_ff;
      edge_in       = edge_ff;
      found_in      = found_ff;
      still_in      = still_ff;
      s2_clear_in   = 1'b0;
      s2_pvalid_in  = 1'b0;
      s2_preset_in  = '0;
      err_pos_w     = '0;
      err_vel_w     = '0;
      if (!is_tick) begin
         // start: capture encoder, ask for a latch clear
         desired_in  = pos_w;
         previous_in = pos_w;
         still_in    = '0;
         s2_clear_in = 1'b1;
      end else if (is_active) begin
         if (phase_ff == eih_pkg::PH_WAITLOW && idx_low) begin
            edge_in = POS_BITS'(s1_reread_ff);
         end
         if (phase_ff == eih_pkg::PH_TRAVEL && idx_low && travel_done) begin
            s2_clear_in = 1'b1;
         end
         if (phase_ff == eih_pkg::PH_WAITLATCH && s1_latched_ff) begin
            found_in = POS_BITS'(pair_avg) + POS_BITS'(cfg_home_ff);
            still_in = '0;
         end
         if (lead_over) begin
            desired_in = pos_w + POS_BITS'(cfg_limit_ff);
            err_pos_w  = -POS_BITS'(cfg_limit_ff);
         end else begin
            desired_in = desired_step;
            err_pos_w  = -lead;
         end
         err_vel_w   = pos_w - previous_ff;
         previous_in = pos_w;
      end else if (phase_ff == eih_pkg::PH_SETTLE) begin
         still_in    = still_step;
         previous_in = pos_w;
         if (still_done) begin
            s2_pvalid_in = 1'b1;
            s2_preset_in = preset_w[FB-1:0];
         end
      end
      s2_err_pos_in = sat_term(err_pos_w);
      s2_err_vel_in = sat_term(err_vel_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= eih_pkg::PH_IDLE;
      end else if (s2_load) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff  <= '0;
         previous_ff <= '0;
         edge_ff     <= '0;
         found_ff    <= '0;
         still_ff    <= '0;
      end else if (s2_load) begin
         desired_ff  <= desired_in;
         previous_ff <= previous_in;
         edge_ff     <= edge_in;
         found_ff    <= found_in;
         still_ff    <= still_in;
      end
   end

   logic signed [ERR_BITS-1:0] s2_err_pos_ff, s2_err_vel_ff;
   logic                       s2_clear_ff, s2_pvalid_ff;
   logic [eih_pkg::PHASE_BITS-1:0] s2_phase_ff;
   logic signed [FB-1:0]       s2_preset_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_err_pos_ff <= s2_err_pos_in;
         s2_err_vel_ff <= s2_err_vel_in;
         s2_clear_ff   <= s2_clear_in;
         s2_pvalid_ff  <= s2_pvalid_in;
         s2_preset_ff  <= s2_preset_in;
         s2_phase_ff   <= phase_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: PD drive, saturated, into the result register
   // ------------------------------------------------------------------------
   logic signed [PROD_BITS-1:0]  prod_pos, prod_vel;
   logic signed [SUM_BITS-1:0]   drive_sum;
   logic signed [DRIVE_BITS-1:0] drive_in;

   assign prod_pos  = s2_err_pos_ff * $signed({1'b0, cfg_kp_ff});
   assign prod_vel  = s2_err_vel_ff * $signed({1'b0, cfg_kd_ff});
   assign drive_sum = SUM_BITS'(prod_pos) + SUM_BITS'(prod_vel);

   always_comb begin
      if (drive_sum > DRV_HI) begin
         drive_in = DRIVE_BITS'(DRV_HI);
      end else if (drive_sum < DRV_LO) begin
         drive_in = DRIVE_BITS'(DRV_LO);
      end else begin
         drive_in = DRIVE_BITS'(drive_sum);
      end
   end

   logic signed [DRIVE_BITS-1:0]   drive_ff;
   logic                           clear_ff, pvalid_ff;
   logic [eih_pkg::PHASE_BITS-1:0] phase_out_ff;
   logic signed [FB-1:0]           preset_ff;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         drive_ff     <= drive_in;
         clear_ff     <= s2_clear_ff;
         pvalid_ff    <= s2_pvalid_ff;
         preset_ff    <= s2_preset_ff;
         phase_out_ff <= s2_phase_ff;
      end
   end

   assign rsp_valid        = s3_valid_ff;
   assign rsp_drive        = drive_ff;
   assign rsp_clear_latch  = clear_ff;
   assign rsp_phase        = phase_out_ff;
   assign rsp_preset_valid = pvalid_ff;
   assign rsp_preset_value = preset_ff;

`ifndef SYNTH
   // A preset is only issued on the transaction that finishes homing
   a_preset_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_preset_valid) |-> (rsp_phase == eih_pkg::PH_DONE))
      else $error("preset issued outside the done phase");

   // Drive is nonzero only while the axis is moving toward the index
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive != '0) |->
         (rsp_phase == eih_pkg::PH_WAITLOW || rsp_phase == eih_pkg::PH_TRAVEL ||
          rsp_phase == eih_pkg::PH_WAITLATCH || rsp_phase == eih_pkg::PH_SETTLE))
      else $error("drive active outside the homing phases");

   // A latch clear comes with a start or with arming the latch
   a_clear_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clear_latch) |->
         (rsp_phase == eih_pkg::PH_WAITLOW || rsp_phase == eih_pkg::PH_WAITLATCH))
      else $error("latch clear in an unexpected phase");

   // The homing state moves only when a transaction enters the state stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(s2_load) |-> $stable(phase_ff))
      else $error("phase changed without a transaction");
`endif

endmodule

// ===== test/encoder_index_homing_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// encoder_index_homing_test: self-checking bench for the index homing block
// Sends start and tick transactions in complete homing runs, cut-short runs
// and random noise under several register settings. A scoreboard predicts
// each result and checks every result field by field.
// ============================================================================
module encoder_index_homing_test;
   import eih_pkg::*;

   localparam int RESULT_LATENCY = 3;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CAP     = 40;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int ROUNDS         = 6;
   localparam int REPORT_LIMIT   = 10;
   localparam longint DRIVE_MAX  = (longint'(1) <<< (DRIVE_BITS_DEFAULT - 1)) - 1;
   localparam longint DRIVE_MIN  = -DRIVE_MAX - 1;

   typedef struct packed {
      logic signed [DRIVE_BITS_DEFAULT-1:0] drive;
      logic                                 clear_latch;
      phase_type                            phase;
      logic                                 preset_valid;
      logic signed [FIELD_BITS-1:0]         preset_value;
   } homing_result_t;

   // Scoreboard: homing state predictor and queue of expected results
   class homing_scoreboard;
      logic [STEP_BITS-1:0]         step_per_tick;
      logic [LIMIT_BITS-1:0]        error_limit;
      logic [GAIN_BITS-1:0]         gain_position;
      logic [GAIN_BITS-1:0]         gain_velocity;
      logic [LIMIT_BITS-1:0]        travel_minimum;
      logic [LIMIT_BITS-1:0]        still_needed;
      logic signed [FIELD_BITS-1:0] home_offset;
      phase_type                    phase;
      logic signed [FIELD_BITS-1:0] desired_cnt;
      logic signed [FIELD_BITS-1:0] previous_cnt;
      logic signed [FIELD_BITS-1:0] edge_cnt;
      logic signed [FIELD_BITS-1:0] found_offset;
      logic [STILL_BITS-1:0]        still_cnt;
      homing_result_t               pending[$];
      int                           errors;
      int                           checked;
      int                           presets;

      function new();
         step_per_tick  = RST_STEP_PER_TICK;
         error_limit    = RST_ERROR_LIMIT;
         gain_position  = RST_GAIN_POSITION;
         gain_velocity  = RST_GAIN_VELOCITY;
         travel_minimum = RST_TRAVEL_MINIMUM;
         still_needed   = RST_STILL_NEEDED;
         home_offset    = RST_HOME_OFFSET;
         phase          = PH_IDLE;
         desired_cnt    = '0;
         previous_cnt   = '0;
         edge_cnt       = '0;
         found_offset   = '0;
         still_cnt      = '0;
         errors         = 0;
         checked        = 0;
         presets        = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [FIELD_BITS-1:0] val);
         case (idx)
            CSR_STEP_PER_TICK:  step_per_tick  = val[STEP_BITS-1:0];
            CSR_ERROR_LIMIT:    error_limit    = val[LIMIT_BITS-1:0];
            CSR_GAIN_POSITION:  gain_position  = val[GAIN_BITS-1:0];
            CSR_GAIN_VELOCITY:  gain_velocity  = val[GAIN_BITS-1:0];
            CSR_TRAVEL_MINIMUM: travel_minimum = val[LIMIT_BITS-1:0];
            CSR_STILL_NEEDED:   still_needed   = val[LIMIT_BITS-1:0];
            CSR_HOME_OFFSET:    home_offset    = val;
            default: ;
         endcase
      endfunction

      // Advance the homing state by one accepted transaction
      function void note_input(logic kind, logic signed [FIELD_BITS-1:0] pos,
                               logic signed [FIELD_BITS-1:0] reread,
                               logic index_level, logic index_latched);
         homing_result_t r;
         int             gap;
         longint         ep;
         longint         ev;
         longint         drv;
         longint         avg;
         r = '0;
         if (kind == KIND_START) begin
            desired_cnt   = pos;
            previous_cnt  = pos;
            still_cnt     = '0;
            phase         = PH_WAITLOW;
            r.clear_latch = 1'b1;
         end else if (phase == PH_WAITLOW || phase == PH_TRAVEL || phase == PH_WAITLATCH) begin
            case (phase)
               PH_WAITLOW: begin
                  if (!index_level) begin
                     edge_cnt = reread;
                     phase    = PH_TRAVEL;
                  end
               end
               PH_TRAVEL: begin
                  gap = pos - edge_cnt;
                  if (index_level) begin
                     phase = PH_WAITLOW;
                  end else if (gap > int'(travel_minimum)) begin
                     r.clear_latch = 1'b1;
                     phase         = PH_WAITLATCH;
                  end
               end
               default: begin
                  if (index_latched) begin
                     // average of both reads, truncated toward zero
                     avg          = (longint'(pos) + longint'(reread)) / 2;
                     found_offset = FIELD_BITS'(avg + longint'(home_offset));
                     still_cnt    = '0;
                     phase        = PH_SETTLE;
                  end
               end
            endcase
            // advance the target, never more than the error limit ahead
            desired_cnt = desired_cnt + step_per_tick;
            gap = desired_cnt - pos;
            if (gap > int'(error_limit))
               desired_cnt = pos + error_limit;
            gap = pos - desired_cnt;
            ep  = longint'(gap);
            gap = pos - previous_cnt;
            ev  = longint'(gap);
            drv = longint'(gain_position) * ep + longint'(gain_velocity) * ev;
            if (drv > DRIVE_MAX)
               drv = DRIVE_MAX;
            else if (drv < DRIVE_MIN)
               drv = DRIVE_MIN;
            r.drive      = drv[DRIVE_BITS_DEFAULT-1:0];
            previous_cnt = pos;
         end else if (phase == PH_SETTLE) begin
            if (pos == previous_cnt) begin
               if (still_cnt != STILL_MAX)
                  still_cnt = still_cnt + 1'b1;
            end else begin
               still_cnt = '0;
            end
            previous_cnt = pos;
            if (still_cnt > still_needed) begin
               r.preset_value = pos - found_offset;
               r.preset_valid = 1'b1;
               phase          = PH_DONE;
            end
         end
         r.phase = phase;
         pending.push_back(r);
      endfunction

      // Compare one result transaction with the oldest expectation
      function void check_result(logic signed [DRIVE_BITS_DEFAULT-1:0] drive,
                                 logic clear_latch, logic [PHASE_BITS-1:0] ph,
                                 logic preset_valid,
                                 logic signed [FIELD_BITS-1:0] preset_value);
         homing_result_t exp_r;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("result with no transaction pending: drive %0d phase %0d",
                        drive, ph);
            return;
         end
         exp_r = pending.pop_front();
         checked++;
         if (drive !== exp_r.drive || clear_latch !== exp_r.clear_latch ||
             ph !== exp_r.phase || preset_valid !== exp_r.preset_valid ||
             preset_value !== exp_r.preset_value) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("result %0d: expected drive %0d clear %0b phase %0d preset %0b:%0d",
                        checked, exp_r.drive, exp_r.clear_latch, exp_r.phase,
                        exp_r.preset_valid, exp_r.preset_value);
               $display("   actual drive %0d clear %0b phase %0d preset %0b:%0d",
                        drive, clear_latch, ph, preset_valid, preset_value);
            end
         end else if (exp_r.preset_valid) begin
            presets++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index = '0;
   logic [FIELD_BITS-1:0]         csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_kind = KIND_START;
   logic signed [FIELD_BITS-1:0]  req_position = '0;
   logic signed [FIELD_BITS-1:0]  req_position_reread = '0;
   logic                          req_index_level = 1'b0;
   logic                          req_index_latched = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [DRIVE_BITS_DEFAULT-1:0] rsp_drive;
   logic                          rsp_clear_latch;
   logic [PHASE_BITS-1:0]         rsp_phase;
   logic                          rsp_preset_valid;
   logic signed [FIELD_BITS-1:0]  rsp_preset_value;

   homing_scoreboard sb = new();
   int send_idle_pct = 19;
   int recv_idle_pct = 78;
   int sent_items    = 0;
   int quiet_cycles  = 0;
   int settings_used = 0;

   encoder_index_homing u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_position        (req_position),
      .req_position_reread (req_position_reread),
      .req_index_level     (req_index_level),
      .req_index_latched   (req_index_latched),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive           (rsp_drive),
      .rsp_clear_latch     (rsp_clear_latch),
      .rsp_phase           (rsp_phase),
      .rsp_preset_valid    (rsp_preset_valid),
      .rsp_preset_value    (rsp_preset_value)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Note accepted transactions and check results on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_input(req_kind, req_position, req_position_reread,
                          req_index_level, req_index_latched);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_drive, rsp_clear_latch, rsp_phase,
                            rsp_preset_valid, rsp_preset_value);
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("encoder_index_homing_test NOT OK");
         $finish;
      end
   end

   // Present one transaction after a random gap and hold it until accepted
   task automatic send_item(input logic kind, input logic signed [FIELD_BITS-1:0] pos,
                            input logic signed [FIELD_BITS-1:0] reread,
                            input logic index_level, input logic index_latched);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_position        <= pos;
      req_position_reread <= reread;
      req_index_level     <= index_level;
      req_index_latched   <= index_latched;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent_items++;
   endtask

   // Hold the sender until every expected result has arrived
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [FIELD_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // One homing run with random content, sometimes cut short
   task automatic homing_run();
      logic signed [FIELD_BITS-1:0] pos;
      logic signed [FIELD_BITS-1:0] edge_at;
      logic signed [FIELD_BITS-1:0] reread;
      int                           stop_after;
      int                           steps;
      int                           inc_max;
      int                           n;
      stop_after = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4;
      pos = $urandom;
      send_item(KIND_START, pos, $urandom, 1'($urandom), 1'($urandom));
      // hold the index high for a few ticks
      repeat ($urandom_range(0, 3)) begin
         pos = pos + $urandom_range(0, 60);
         send_item(KIND_TICK, pos, $urandom, 1'b1, 1'($urandom));
      end
      // index goes low; the reread marks where travel counts from
      edge_at = pos + $urandom_range(0, 4) - 2;
      send_item(KIND_TICK, pos, edge_at, 1'b0, 1'($urandom));
      if (stop_after < 2)
         return;
      // travel past the minimum, with the odd index glitch
      inc_max = int'(sb.travel_minimum) / 3 + 2;
      steps   = 0;
      while (int'(pos - edge_at) <= int'(sb.travel_minimum) && steps < 40) begin
         pos = pos + $urandom_range(0, inc_max) - inc_max / 8;
         if ($urandom_range(0, 19) == 0) begin
            send_item(KIND_TICK, pos, $urandom, 1'b1, 1'($urandom));
            edge_at = pos;
            send_item(KIND_TICK, pos, edge_at, 1'b0, 1'($urandom));
         end else begin
            send_item(KIND_TICK, pos, $urandom, 1'b0, 1'($urandom));
         end
         steps++;
      end
      if (stop_after < 3)
         return;
      // wait for the latch, then latch with a nearby or a wild reread
      repeat ($urandom_range(0, 3)) begin
         pos = pos + $urandom_range(0, 30);
         send_item(KIND_TICK, pos, $urandom, 1'($urandom), 1'b0);
      end
      pos = pos + $urandom_range(0, 30);
      if ($urandom_range(0, 3) == 0)
         reread = $urandom;
      else
         reread = pos + $urandom_range(0, 6) - 3;
      send_item(KIND_TICK, pos, reread, 1'($urandom), 1'b1);
      if (stop_after < 4)
         return;
      // settle: a nudge or two, then stand still long enough for the preset where SETTLE_CAP allows
      repeat ($urandom_range(0, 2)) begin
         pos = pos + $urandom_range(0, 2) - 1;
         send_item(KIND_TICK, pos, $urandom, 1'($urandom), 1'($urandom));
      end
      n = int'(sb.still_needed) + 2;
      if (n > SETTLE_CAP)
         n = SETTLE_CAP;
      repeat (n)
         send_item(KIND_TICK, pos, $urandom, 1'($urandom), 1'($urandom));
      // ticks once done are ignored by the sequencer
      repeat ($urandom_range(0, 2))
         send_item(KIND_TICK, $urandom, $urandom, 1'($urandom), 1'($urandom));
   endtask

   initial begin
      int                           round;
      int                           target;
      logic [STEP_BITS-1:0]         step;
      logic [LIMIT_BITS-1:0]        err_lim;
      logic [GAIN_BITS-1:0]         kp;
      logic [GAIN_BITS-1:0]         kv;
      logic [LIMIT_BITS-1:0]        travel;
      logic [LIMIT_BITS-1:0]        still;
      logic signed [FIELD_BITS-1:0] home;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, wrap, glitch, restart and truncation cases
      send_item(KIND_TICK, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1);  // idle tick
      send_item(KIND_START, 32'sh7FFF_FFF0, 32'sh0000_0000, 1'b1, 1'b0);
      send_item(KIND_TICK, 32'sh8000_0010, 32'sh8000_0010, 1'b1, 1'b0);  // wraps
      send_item(KIND_TICK, 32'sh8000_0020, 32'sh8000_0021, 1'b0, 1'b0);  // to travel
      send_item(KIND_TICK, 32'sh8000_0022, 32'sh8000_0022, 1'b1, 1'b0);  // glitch back
      send_item(KIND_TICK, 32'sd100, 32'sd100, 1'b0, 1'b1);              // saturates
      send_item(KIND_TICK, 32'sd900, -32'sd1, 1'b0, 1'b0);               // exactly min
      send_item(KIND_TICK, 32'sd901, 32'sd0, 1'b0, 1'b0);                // past min
      send_item(KIND_TICK, -32'sd50000, 32'sd0, 1'b1, 1'b0);             // target clamps
      send_item(KIND_START, 32'sd0, 32'sh7FFF_FFFF, 1'b0, 1'b1);         // restart
      send_item(KIND_TICK, 32'sd0, 32'sd0, 1'b0, 1'b1);
      send_item(KIND_TICK, 32'sh7FFF_FFFF, 32'sd0, 1'b0, 1'b0);
      send_item(KIND_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0);
      send_item(KIND_TICK, -32'sd7, 32'sd2, 1'b1, 1'b1);                 // odd negative sum
      send_item(KIND_TICK, -32'sd6, 32'sd0, 1'b0, 1'b0);
      send_item(KIND_TICK, -32'sd6, 32'sd0, 1'b1, 1'b1);
      send_item(KIND_TICK, -32'sd6, 32'sd0, 1'b0, 1'b1);

      for (round = 0; round < ROUNDS; round++) begin
         if (round < 2) begin
            send_idle_pct = 19;
            recv_idle_pct = 78;
         end else if (round < 4) begin
            send_idle_pct = 78;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // pick the settings for this round
         case (round)
            0: begin
               step = '0; err_lim = '0; kp = '0; kv = '0; travel = '0; still = '0;
               home = 32'sh8000_0000;
            end
            2: begin
               step = '1; err_lim = '1; kp = '1; kv = '1; travel = '1; still = '1;
               home = 32'sh7FFF_FFFF;
            end
            4: begin
               step = RST_STEP_PER_TICK; err_lim = RST_ERROR_LIMIT;
               kp = RST_GAIN_POSITION; kv = RST_GAIN_VELOCITY;
               travel = RST_TRAVEL_MINIMUM; still = 16'd5; home = $urandom;
            end
            default: begin
               step    = STEP_BITS'($urandom_range(0, 4095));
               err_lim = LIMIT_BITS'($urandom_range(0, 65535));
               kp      = GAIN_BITS'($urandom_range(0, 255));
               kv      = GAIN_BITS'($urandom_range(0, 255));
               travel  = LIMIT_BITS'($urandom_range(0, 300));
               still   = LIMIT_BITS'($urandom_range(0, 12));
               home    = $urandom;
            end
         endcase
         // write the registers only once the block has gone quiet
         drain();
         repeat (RESULT_LATENCY + 1) @(posedge clock);
         write_reg(CSR_STEP_PER_TICK, FIELD_BITS'(step));
         write_reg(CSR_ERROR_LIMIT, FIELD_BITS'(err_lim));
         write_reg(CSR_GAIN_POSITION, FIELD_BITS'(kp));
         write_reg(CSR_GAIN_VELOCITY, FIELD_BITS'(kv));
         write_reg(CSR_TRAVEL_MINIMUM, FIELD_BITS'(travel));
         write_reg(CSR_STILL_NEEDED, FIELD_BITS'(still));
         write_reg(CSR_HOME_OFFSET, home);
         csr_we <= 1'b0;
         settings_used++;

         target = sent_items + RANDOM_ITEMS / ROUNDS;
         while (sent_items < target) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 6))
                  send_item(($urandom_range(0, 3) == 0) ? KIND_START : KIND_TICK,
                            $urandom, $urandom, 1'($urandom), 1'($urandom));
            end else begin
               homing_run();
            end
            if ($urandom_range(0, 9) == 0)
               drain();
         end
      end

      drain();
      repeat (RESULT_LATENCY + 4) @(posedge clock);

      $display("run covered %0d transactions, %0d results checked, %0d presets issued",
               sent_items, sb.checked, sb.presets);
      $display("over %0d register settings plus reset values, %0d mismatches",
               settings_used, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("encoder_index_homing_test OK");
      end else begin
         if (sb.pending.size() != 0)
            $display("%0d expected results never arrived", sb.pending.size());
         $display("encoder_index_homing_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/eih_pkg.sv
hw/rtl/encoder_index_homing.sv
test/encoder_index_homing_test.sv
